@@ hdl/rgbhsv_pkg.sv @@
// rgbhsv_pkg: widths, hue sector codes, hue base angles and pipeline stage types
// shared by the rgb to hsv converter; depends on nothing
package rgbhsv_pkg;

  localparam int ChanW     = 8;
  localparam int HueW      = 9;
  localparam int SatW      = 8;
  localparam int HueNumW   = 17;   // numerator below 360 * 255
  localparam int SatNumW   = 16;   // numerator 255 * (max - min)
  localparam int DiffW     = ChanW + 1;
  localparam int HueSumW   = HueNumW + 2;
  localparam int DivStages = HueW; // one quotient bit per stage, hue is the wider one

  // hue base angles in degrees for each sector
  localparam logic [HueW-1:0] HueBaseRed   = HueW'(0);
  localparam logic [HueW-1:0] HueBaseWrap  = HueW'(360);
  localparam logic [HueW-1:0] HueBaseGreen = HueW'(120);
  localparam logic [HueW-1:0] HueBaseBlue  = HueW'(240);
  localparam int              HueSlope     = 60;

  typedef enum logic [1:0] {
    SEC_RED   = 2'b00,
    SEC_GREEN = 2'b01,
    SEC_BLUE  = 2'b10
  } sector_t;

  // first front stage: channels with their max and min
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] mn;
  } ext_t;

  // second front stage: sector, signed channel difference, spread
  typedef struct packed {
    sector_t                 sector;
    logic signed [DiffW-1:0] diff;
    logic [ChanW-1:0]        spread;
    logic [ChanW-1:0]        mx;
  } sec_t;

  // divider lanes, one entry per pipeline stage
  typedef struct packed {
    logic [HueNumW-1:0] hue_rem;
    logic [ChanW-1:0]   hue_den;
    logic [HueW-1:0]    hue_quo;
    logic [SatNumW-1:0] sat_rem;
    logic [ChanW-1:0]   sat_den;
    logic [SatW-1:0]    sat_quo;
    logic [ChanW-1:0]   brightness;
  } div_t;

endpackage

@@ hdl/rgbhsv_pix_if.sv @@
// rgbhsv_pix_if: valid/ready channel carrying one rgb pixel
// depends on rgbhsv_pkg
interface rgbhsv_pix_if;
  import rgbhsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

@@ hdl/rgbhsv_hsv_if.sv @@
// rgbhsv_hsv_if: valid/ready channel carrying one hsv result
// depends on rgbhsv_pkg
interface rgbhsv_hsv_if;
  import rgbhsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [SatW-1:0]  saturation;
  logic [ChanW-1:0] brightness;

  modport source(output valid, output hue, output saturation, output brightness, input ready);
  modport sink(input valid, input hue, input saturation, input brightness, output ready);
endinterface

@@ hdl/rgbhsv_front.sv @@
// rgbhsv_front: three pipeline stages that find max/min, the hue sector and the
// divider numerators and divisors; depends on rgbhsv_pkg and rgbhsv_pix_if
module rgbhsv_front (
  input  logic               clk,
  input  logic               rst,
  rgbhsv_pix_if.sink         pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output rgbhsv_pkg::div_t   out_data
);
  import rgbhsv_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  ext_t ext, ext_next;
  sec_t sec, sec_next;
  div_t num, num_next;

  logic [HueW-1:0]          base;
  logic [HueNumW-1:0]       base_term;
  logic signed [HueSumW-1:0] diff_ext;
  logic signed [HueSumW-1:0] slope_term;
  logic signed [HueSumW-1:0] hue_sum;

  assign rdy3        = !v3 || out_ready;
  assign rdy2        = !v2 || rdy3;
  assign rdy1        = !v1 || rdy2;
  assign pixel.ready = rdy1;
  assign out_valid   = v3;
  assign out_data    = num;

  // stage 1: max and min
  always_comb begin
    ext_next.red   = pixel.red_in;
    ext_next.green = pixel.green_in;
    ext_next.blue  = pixel.blue_in;
    ext_next.mx    = pixel.red_in;
    ext_next.mn    = pixel.red_in;
    if (pixel.green_in > ext_next.mx) ext_next.mx = pixel.green_in;
    if (pixel.blue_in > ext_next.mx)  ext_next.mx = pixel.blue_in;
    if (pixel.green_in < ext_next.mn) ext_next.mn = pixel.green_in;
    if (pixel.blue_in < ext_next.mn)  ext_next.mn = pixel.blue_in;
  end

  // stage 2: sector by max channel, red first then green
  always_comb begin
    sec_next.spread = ext.mx - ext.mn;
    sec_next.mx     = ext.mx;
    priority if (ext.mx == ext.red) begin
      sec_next.sector = SEC_RED;
      sec_next.diff   = $signed({1'b0, ext.green}) - $signed({1'b0, ext.blue});
    end else if (ext.mx == ext.green) begin
      sec_next.sector = SEC_GREEN;
      sec_next.diff   = $signed({1'b0, ext.blue}) - $signed({1'b0, ext.red});
    end else begin
      sec_next.sector = SEC_BLUE;
      sec_next.diff   = $signed({1'b0, ext.red}) - $signed({1'b0, ext.green});
    end
  end

  // stage 3: hue numerator base*spread + 60*diff, never negative
  always_comb begin
    unique case (sec.sector)
      SEC_RED:   base = (sec.diff < 0) ? HueBaseWrap : HueBaseRed;
      SEC_GREEN: base = HueBaseGreen;
      SEC_BLUE:  base = HueBaseBlue;
      default:   base = HueBaseRed;
    endcase
    base_term  = HueNumW'(sec.spread) * HueNumW'(base);
    diff_ext   = HueSumW'(sec.diff);
    slope_term = diff_ext * HueSumW'(HueSlope);
    hue_sum    = $signed({2'b00, base_term}) + slope_term;

    num_next.hue_rem    = hue_sum[HueNumW-1:0];
    // zero spread means a zero numerator, so a divisor of one gives zero
    num_next.hue_den    = (sec.spread == '0) ? ChanW'(1) : sec.spread;
    num_next.hue_quo    = '0;
    num_next.sat_rem    = {sec.spread, {ChanW{1'b0}}} - SatNumW'(sec.spread);
    num_next.sat_den    = (sec.mx == '0) ? ChanW'(1) : sec.mx;
    num_next.sat_quo    = '0;
    num_next.brightness = sec.mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pixel.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) ext <= ext_next;
    if (rdy2) sec <= sec_next;
    if (rdy3) num <= num_next;
  end

endmodule

@@ hdl/rgbhsv_div_pipe.sv @@
// rgbhsv_div_pipe: restoring division pipeline, one quotient bit per stage,
// hue and saturation lanes side by side; depends on rgbhsv_pkg
module rgbhsv_div_pipe (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rgbhsv_pkg::div_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rgbhsv_pkg::div_t out_data
);
  import rgbhsv_pkg::*;

  // one restoring step at quotient bit position pos
  function automatic div_t div_step(div_t x, int unsigned pos);
    div_t               y;
    logic [HueNumW-1:0] hue_sh;
    logic [SatNumW-1:0] sat_sh;
    y      = x;
    hue_sh = HueNumW'(x.hue_den) << pos;
    sat_sh = SatNumW'(x.sat_den) << pos;
    if (x.hue_rem >= hue_sh) begin
      y.hue_rem = x.hue_rem - hue_sh;
      y.hue_quo = x.hue_quo | (HueW'(1) << pos);
    end
    if (pos < SatW && x.sat_rem >= sat_sh) begin
      y.sat_rem = x.sat_rem - sat_sh;
      y.sat_quo = x.sat_quo | (SatW'(1) << pos);
    end
    return y;
  endfunction

  div_t                 st  [DivStages];
  logic [DivStages-1:0] vld;
  logic [DivStages-1:0] rdy;

  assign in_ready  = rdy[0];
  assign out_valid = vld[DivStages-1];
  assign out_data  = st[DivStages-1];

  for (genvar i = 0; i < DivStages; i++) begin : g_stage
    localparam int unsigned Pos = DivStages - 1 - i;
    div_t prev_data;
    logic prev_valid;
    logic next_ready;

    if (i == 0) begin : g_first
      assign prev_data  = in_data;
      assign prev_valid = in_valid;
    end else begin : g_mid
      assign prev_data  = st[i-1];
      assign prev_valid = vld[i-1];
    end

    if (i == DivStages - 1) begin : g_last
      assign next_ready = out_ready;
    end else begin : g_inner
      assign next_ready = rdy[i+1];
    end

    assign rdy[i] = !vld[i] || next_ready;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) st[i] <= div_step(prev_data, Pos);
    end
  end

endmodule

@@ hdl/rgb_to_hsv_converter.sv @@
// rgb_to_hsv_converter: top level, 8-bit rgb pixel in, hue/saturation/value out
// depends on rgbhsv_pkg, rgbhsv_pix_if, rgbhsv_hsv_if, rgbhsv_front, rgbhsv_div_pipe
//
//   port    dir  payload                          transfer when
//   pixel   in   red_in, green_in, blue_in        pixel.valid && pixel.ready
//   result  out  hue, saturation, brightness      result.valid && result.ready
//
// one pixel per clock sustained while result.ready is high; 3 front stages (max/min,
// sector, numerators) and 9 divider stages, one quotient bit each.
// every stage has its own valid bit and loads when empty or when the next one
// moves, so bubbles close up under a stalled output and nothing is dropped.
// rst is synchronous and clears only the valid bits.
module rgb_to_hsv_converter (
  input  logic         clk,
  input  logic         rst,
  rgbhsv_pix_if.sink   pixel,
  rgbhsv_hsv_if.source result
);
  import rgbhsv_pkg::*;

  logic front_valid;
  logic front_ready;
  div_t front_data;
  div_t div_data;

  rgbhsv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  rgbhsv_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (div_data)
  );

  assign result.hue        = div_data.hue_quo;
  assign result.saturation = div_data.sat_quo;
  assign result.brightness = div_data.brightness;

endmodule
